>>> hdl/nbd32_pkg.sv
package nbd32_pkg;

    localparam int KEY_W  = 64;
    localparam int WORD_W = 32;
    localparam int BTN_W  = 4;
    localparam int DISC_W = 10;
    localparam int OVF_W  = 2;
    localparam int SYNC_W = 16;

    // nonlinear function table after reset
    localparam logic [WORD_W-1:0] NLF_RESET = 32'h3A5C742E;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] ciphertext;
        logic [BTN_W-1:0]  clear_button;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] plaintext;
        logic [BTN_W-1:0]  decrypted_button;
        logic [OVF_W-1:0]  overflow_bits;
        logic [DISC_W-1:0] discriminator;
        logic [SYNC_W-1:0] sync_counter;
        logic              button_match;
    } t_out;

    // item as it travels through the round stages
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] word;
        logic [BTN_W-1:0]  clear_button;
    } t_pipe;

    // one decryption round: shift left, feedback into bit 0
    function automatic logic [WORD_W-1:0] round_fn(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] nlf,
        input logic              kbit
    );
        logic [4:0] sel;
        logic       fb;
        sel = {x[30], x[25], x[19], x[8], x[0]};
        fb  = x[31] ^ x[15] ^ nlf[sel] ^ kbit;
        return {x[WORD_W-2:0], fb};
    endfunction

endpackage

>>> hdl/nbd32_stage.sv
module nbd32_stage #(
    parameter int STAGE_IDX        = 0,
    parameter int ROUNDS_PER_STAGE = 16,
    parameter int ROUND_COUNT      = 528
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_nlf_table,
    input  logic               i_valid,
    output logic               o_ready,
    input  nbd32_pkg::t_pipe   i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output nbd32_pkg::t_pipe   o_item
);

    logic [nbd32_pkg::WORD_W-1:0] w_x [0:ROUNDS_PER_STAGE];
    nbd32_pkg::t_pipe r_item, n_item;
    logic             r_valid;

    assign w_x[0] = i_item.word;

    for (genvar j = 0; j < ROUNDS_PER_STAGE; j++) begin : g_round
        localparam int RIDX = STAGE_IDX * ROUNDS_PER_STAGE + j;
        localparam int KPOS = ((15 - RIDX) % 64 + 64) % 64;
        if (RIDX < ROUND_COUNT) begin : g_act
            assign w_x[j+1] = nbd32_pkg::round_fn(w_x[j], i_nlf_table, i_item.key[KPOS]);
        end else begin : g_pass
            assign w_x[j+1] = w_x[j];
        end
    end

    always_comb begin
        n_item      = i_item;
        n_item.word = w_x[ROUNDS_PER_STAGE];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> hdl/nbd32_out.sv
module nbd32_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  nbd32_pkg::t_pipe   i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output nbd32_pkg::t_out    o_data
);

    nbd32_pkg::t_out r_data, n_data;
    logic            r_valid;

    // split plaintext into fields, check button against the clear copy
    always_comb begin
        n_data.plaintext        = i_item.word;
        n_data.decrypted_button = i_item.word[31:28];
        n_data.overflow_bits    = i_item.word[27:26];
        n_data.discriminator    = i_item.word[25:16];
        n_data.sync_counter     = i_item.word[15:0];
        n_data.button_match     = (i_item.word[31:28] == i_item.clear_button);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/nlfsr_block_decrypt_32_core.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+---------------------------
// input     | in        | i_in_valid / o_in_ready    | i_in_data  (key, ct, button)
// result    | out       | o_out_valid / i_out_ready  | o_out_data (plaintext, fields)
// config    | in        | i_cfg_wr_en                | i_cfg_wr_data (nlf table)
//
// One item accepted per cycle while the output does not stall. Each item passes
// through ceil(ROUND_COUNT / ROUNDS_PER_STAGE) round stages
// (ROUNDS_PER_STAGE unrolled rounds each), then the field/output register.
// Reset (synchronous, active low) empties every stage and restores the table.
// A stall at the output holds each full stage; empty stages keep filling,
// so bubbles collapse and no item is lost or repeated.
module nlfsr_block_decrypt_32_core #(
    parameter int ROUND_COUNT      = 528,
    parameter int ROUNDS_PER_STAGE = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  nbd32_pkg::t_in    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output nbd32_pkg::t_out   o_out_data,
    input  logic              i_cfg_wr_en,
    input  logic [31:0]       i_cfg_wr_data
);

    localparam int NSTAGE = (ROUND_COUNT + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;

    // nonlinear function table; the user must rewrite it only while the pipe is empty
    // (the block does not enforce this), so every stage reads it directly
    logic [31:0] r_nlf_table;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nlf_table <= nbd32_pkg::NLF_RESET;
        end else if (i_cfg_wr_en) begin
            r_nlf_table <= i_cfg_wr_data;
        end
    end

    // stage chain: index s feeds stage s, stage s drives index s+1
    nbd32_pkg::t_pipe w_item  [0:NSTAGE];
    logic [NSTAGE:0]  w_valid;
    logic [NSTAGE:0]  w_ready;

    assign w_item[0].key          = i_in_data.key;
    assign w_item[0].word         = i_in_data.ciphertext;
    assign w_item[0].clear_button = i_in_data.clear_button;
    assign w_valid[0]             = i_in_valid;
    assign o_in_ready             = w_ready[0];

    for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
        nbd32_stage #(
            .STAGE_IDX        (s),
            .ROUNDS_PER_STAGE (ROUNDS_PER_STAGE),
            .ROUND_COUNT      (ROUND_COUNT)
        ) u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_nlf_table (r_nlf_table),
            .i_valid     (w_valid[s]),
            .o_ready     (w_ready[s]),
            .i_item      (w_item[s]),
            .o_valid     (w_valid[s+1]),
            .i_ready     (w_ready[s+1]),
            .o_item      (w_item[s+1])
        );
    end

    // final register: field split and button compare
    nbd32_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NSTAGE]),
        .o_ready (w_ready[NSTAGE]),
        .i_item  (w_item[NSTAGE]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // an empty output register frees the whole chain back to the input
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    // downstream ready propagates to the input through every stage
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("ready chain broken");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.decrypted_button == o_out_data.plaintext[31:28]) &&
                        (o_out_data.sync_counter == o_out_data.plaintext[15:0]))
        else $error("result fields disagree with plaintext");

endmodule
